// ----- src/led_matrix_bar_graph_driver_macros.svh -----
// Assertion macros used by the bar graph driver checker.
`ifndef LED_MATRIX_BAR_GRAPH_DRIVER_MACROS_SVH
`define LED_MATRIX_BAR_GRAPH_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMBG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmbg check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define LMBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbg check failed: next-cycle rule");

`endif

// ----- src/lmbg_pkg.sv -----
// Types and constants for the LED matrix bar graph driver.
`default_nettype none
package lmbg_pkg;

    localparam int unsigned ROWS        = 8;
    localparam int unsigned FRAME_W     = 64;
    localparam logic [7:0]  NOOP_WORD   = 8'h00;
    localparam logic [1:0]  MIRROR_PANEL = 2'd2;
    localparam logic [2:0]  LAST_ROW    = 3'd7;
    localparam logic [3:0]  FULL_HEIGHT = 4'd8;

    // One read-modify-write step handed from the sequencer to the store.
    typedef struct packed {
        logic       en;
        logic [1:0] panel;
        logic [2:0] byte_idx;
        logic [2:0] col;
        logic       lit;
        logic       last;
    } lmbg_step_t;

endpackage
`default_nettype wire

// ----- src/lmbg_seq.sv -----
// Row sequencer: takes a bar command and walks its eight row steps.
`default_nettype none
module lmbg_seq
    import lmbg_pkg::*;
#(
    parameter int PANELS = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] panel,
    input  wire logic [2:0] bar_column,
    input  wire logic [3:0] bar_height,
    input  wire logic       step_ok,
    output lmbg_step_t      step
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [2:0] PanelCount = 3'(PANELS);

    logic       state_reg,  state_next;
    logic [2:0] k_reg,      k_next;
    logic [1:0] panel_reg,  panel_next;
    logic [2:0] col_reg,    col_next;
    logic [3:0] height_reg, height_next;
    logic       up_reg,     up_next;

    logic       accept;
    logic       cmd_ok;
    logic [2:0] row_i;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign cmd_ok   = (bar_height <= FULL_HEIGHT) && ({1'b0, panel} < PanelCount);

    assign row_i = up_reg ? k_reg : (LAST_ROW - k_reg);

    always_comb
    begin
        step.en       = (state_reg == ST_RUN) && step_ok;
        step.panel    = panel_reg;
        step.byte_idx = (panel_reg == MIRROR_PANEL) ? (LAST_ROW - row_i) : row_i;
        step.col      = col_reg;
        step.lit      = ({1'b0, row_i} < height_reg);
        step.last     = (k_reg == LAST_ROW);
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        panel_next  = panel_reg;
        col_next    = col_reg;
        height_next = height_reg;
        up_next     = up_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Drop out-of-range commands without touching the store.
                if (accept && cmd_ok)
                begin
                    state_next  = ST_RUN;
                    k_next      = 3'd0;
                    panel_next  = panel;
                    col_next    = bar_column;
                    height_next = bar_height;
                    up_next     = (bar_height == 4'd0) || (bar_height == FULL_HEIGHT);
                end
            end
            ST_RUN:
            begin
                if (step.en)
                begin
                    k_next = k_reg + 3'd1;
                    if (step.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        panel_reg  <= panel_next;
        col_reg    <= col_next;
        height_reg <= height_next;
        up_reg     <= up_next;
    end

endmodule
`default_nettype wire

// ----- src/lmbg_store.sv -----
// Framebuffer with a single read-modify-write port for one row byte per cycle.
`default_nettype none
module lmbg_store
    import lmbg_pkg::*;
#(
    parameter int PANELS = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lmbg_step_t step,
    output logic [7:0]      new_byte
);

    localparam int DEPTH = PANELS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    mem_reg [DEPTH];
    logic [AW-1:0] addr;
    logic [7:0]    mask;

    assign addr     = AW'({step.panel, step.byte_idx});
    assign mask     = 8'd1 << step.col;
    assign new_byte = step.lit ? (mem_reg[addr] | mask) : (mem_reg[addr] & ~mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < DEPTH; e++)
            begin
                mem_reg[e] <= NOOP_WORD;
            end
        end
        else if (step.en)
        begin
            mem_reg[addr] <= new_byte;
        end
    end

endmodule
`default_nettype wire

// ----- src/led_matrix_bar_graph_driver.sv -----
// Top level of the LED matrix bar graph driver.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  panel, bar_column, bar_height
//  out      source     out_valid/out_ready  chain_frame, last_of_run
//
// A valid command is accepted, then produces eight frames, one per cycle while the output
// is not stalled, paced by the single read-modify-write framebuffer port.
// in_ready is low from acceptance until the eighth frame is loaded; a command
// with a height above 8 or an absent panel is taken and dropped, with no frames.
// A stalled output register stops the sequencer; nothing is lost.
// Reset clears the framebuffer and control state at once.
`default_nettype none
module led_matrix_bar_graph_driver
    import lmbg_pkg::*;
#(
    parameter int PANELS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         panel,
    input  wire logic [2:0]         bar_column,
    input  wire logic [3:0]         bar_height,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FRAME_W-1:0]      chain_frame,
    output logic                    last_of_run
);

    lmbg_step_t step;
    logic       step_ok;
    logic [7:0] new_byte;
    logic [7:0] reg_addr;

    logic               out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0] frame_reg,     frame_next;
    logic               last_reg,      last_next;

    // Advance only when the output register is free or being emptied.
    assign step_ok = !out_valid_reg || out_ready;

    lmbg_seq #(.PANELS(PANELS)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .panel      (panel),
        .bar_column (bar_column),
        .bar_height (bar_height),
        .step_ok    (step_ok),
        .step       (step)
    );

    lmbg_store #(.PANELS(PANELS)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .new_byte (new_byte)
    );

    assign reg_addr = {5'd0, step.byte_idx} + 8'd1;

    always_comb
    begin
        frame_next     = frame_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (step.en)
        begin
            frame_next     = FRAME_W'({reg_addr, new_byte}) << {step.panel, 4'd0};
            last_next      = step.last;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign chain_frame = frame_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

// ----- src/lmbg_checker.sv -----
// Port-level checker for the LED matrix bar graph driver, with its bind.
`default_nettype none
`include "led_matrix_bar_graph_driver_macros.svh"
module lmbg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [3:0]  bar_height,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] chain_frame,
    input wire logic        last_of_run
);

    logic [3:0] slot_used;

    assign slot_used = {|chain_frame[63:48], |chain_frame[47:32],
                        |chain_frame[31:16], |chain_frame[15:0]};

    // Hold a stalled frame.
    `LMBG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(chain_frame) && $stable(last_of_run))
    // A pending frame that is not the last means the run is still going.
    `LMBG_ASSERT_IMPLY(a_busy_mid_run, clk, rst_n, out_valid && !last_of_run, !in_ready)
    // Exactly one panel slot carries a word.
    `LMBG_ASSERT_IMPLY(a_one_slot, clk, rst_n, out_valid, $onehot(slot_used))
    // Drop an over-height command and stay ready.
    `LMBG_ASSERT_NEXT(a_drop_high, clk, rst_n, in_valid && in_ready && (bar_height > 4'd8), in_ready)

endmodule

bind led_matrix_bar_graph_driver lmbg_checker u_lmbg_checker (.*);
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the LED matrix bar graph driver.
`timescale 1ns / 100ps

module tb;
    import lmbg_pkg::*;

    localparam int PANELS         = 4;
    localparam int RANDOM_CMDS    = 250;
    localparam int CHOKE_AFTER    = 120;
    localparam int CHOKE_CYCLES   = 80;
    localparam int DRAIN_AT       = 150;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [1:0] panel;
        logic [2:0] col;
        logic [3:0] height;
        bit         drain;
    } bar_cmd_t;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic               last;
    } row_frame_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         panel = '0;
    logic [2:0]         bar_column = '0;
    logic [3:0]         bar_height = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [FRAME_W-1:0] chain_frame;
    logic               last_of_run;

    bar_cmd_t   pending_cmds[$];
    row_frame_t expected_rows[$];
    logic [7:0] panel_rows [0:3][0:7];

    logic cmd_taken = 1'b0;
    logic frame_taken = 1'b0;
    int   total_cmds = 0;
    int   cmds_accepted = 0;
    int   cmds_ignored = 0;
    int   frames_checked = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    int   send_wait = 0;
    int   send_run = 0;
    int   rx_wait = 0;
    int   rx_run = 0;
    int   choke_left = 0;
    bit   choke_done = 1'b0;

    led_matrix_bar_graph_driver #(
        .PANELS(PANELS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .panel      (panel),
        .bar_column (bar_column),
        .bar_height (bar_height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .chain_frame(chain_frame),
        .last_of_run(last_of_run)
    );

    always #10 clk = ~clk;

    // Idle length for the next item; now and then a run of back-to-back items.
    function automatic int pick_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // Update the shadow framebuffer and queue the eight frames of one bar.
    function automatic void predict_bar(logic [1:0] p, logic [2:0] c, logic [3:0] h);
        logic               upward;
        int                 row;
        int                 bi;
        logic [15:0]        word;
        row_frame_t         fr;
        if (h > FULL_HEIGHT || p >= PANELS)
            return;
        upward = (h == 0) || (h == FULL_HEIGHT);
        for (int k = 0; k < ROWS; k++)
        begin
            row = upward ? k : int'(LAST_ROW) - k;
            bi = (p == MIRROR_PANEL) ? int'(LAST_ROW) - row : row;
            panel_rows[p][bi][c] = (row < h);
            word = ((16'(bi) + 16'd1) << 8) | {8'd0, panel_rows[p][bi]};
            fr.frame = 64'(word) << (16 * p);
            fr.last = (k == ROWS - 1);
            expected_rows.push_back(fr);
        end
    endfunction

    task automatic add_cmd(logic [1:0] p, logic [2:0] c, logic [3:0] h, bit drain = 1'b0);
        bar_cmd_t cmd;
        cmd.panel = p;
        cmd.col = c;
        cmd.height = h;
        cmd.drain = drain;
        pending_cmds.push_back(cmd);
        total_cmds++;
    endtask

    // Sender: hold each item until taken, then wait a gap from pick_gap, possibly zero, before the next one.
    always @(negedge clk)
    begin
        bar_cmd_t cmd;
        if (rst_n && !(in_valid && !cmd_taken))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_rows.size() > 0))
            begin
                cmd = pending_cmds.pop_front();
                panel <= cmd.panel;
                bar_column <= cmd.col;
                bar_height <= cmd.height;
                in_valid <= 1'b1;
                send_wait = pick_gap(send_run);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per frame, plus one long hold-off mid-run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (frame_taken)
                rx_wait = pick_gap(rx_run);
            if (frames_checked >= CHOKE_AFTER && !choke_done)
            begin
                choke_left = CHOKE_CYCLES;
                choke_done = 1'b1;
            end
            if (choke_left > 0)
            begin
                choke_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on every accepted command, check every accepted frame.
    always @(posedge clk)
    begin
        row_frame_t want;
        if (rst_n)
        begin
            cmd_taken <= in_valid && in_ready;
            frame_taken <= out_valid && out_ready;
            if (in_valid && in_ready)
            begin
                cmds_accepted++;
                if (bar_height > FULL_HEIGHT)
                    cmds_ignored++;
                predict_bar(panel, bar_column, bar_height);
            end
            if (out_valid && out_ready)
            begin
                frames_checked++;
                if (expected_rows.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected frame: expected none, got %h last %b",
                             $time, chain_frame, last_of_run);
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (chain_frame !== want.frame)
                    begin
                        errors++;
                        $display("%0t: chain_frame mismatch: expected %h, got %h",
                                 $time, want.frame, chain_frame);
                    end
                    if (last_of_run !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_of_run mismatch: expected %b, got %b",
                                 $time, want.last, last_of_run);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int valid_cmds;
        logic [3:0] h;
        for (int p = 0; p < 4; p++)
            for (int r = 0; r < ROWS; r++)
                panel_rows[p][r] = 8'h00;

        // Directed: every height, both row orders, mirrored panel, edge columns.
        for (int k = 0; k <= 8; k++)
            add_cmd(2'(k % 4), 3'(k), 4'(k));
        add_cmd(2'd2, 3'd0, 4'd3);
        add_cmd(2'd2, 3'd7, 4'd8);
        add_cmd(2'd2, 3'd7, 4'd5);
        add_cmd(2'd2, 3'd0, 4'd0);
        add_cmd(2'd3, 3'd7, 4'd8);
        add_cmd(2'd3, 3'd7, 4'd1);
        add_cmd(2'd0, 3'd0, 4'd8);
        add_cmd(2'd0, 3'd0, 4'd7);
        add_cmd(2'd1, 3'd5, 4'd9);
        add_cmd(2'd3, 3'd7, 4'd15);
        add_cmd(2'd0, 3'd3, 4'd12);
        add_cmd(2'd1, 3'd6, 4'd8);

        valid_cmds = 0;
        while (valid_cmds < RANDOM_CMDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                h = 4'($urandom_range(9, 15));
            end
            else
            begin
                h = 4'($urandom_range(0, 8));
                valid_cmds++;
            end
            add_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), h,
                    valid_cmds == DRAIN_AT && h <= FULL_HEIGHT);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != total_cmds)
            @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d bar commands (%0d with out-of-range height) on %0d panels,",
                 cmds_accepted, cmds_ignored, PANELS);
        $display("checked %0d frames with random stalls, one long output hold-off, %0d errors.",
                 frames_checked, errors);
        if (errors == 0 && expected_rows.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
